// File: hdl/ifrt_pkg.sv
// Package for the IPv4 fragment reassembly tracker.
// Holds the request and response types, the stored entry layouts and status codes.
// No dependencies.
package ifrt_pkg;

   localparam int MAX_GROUPS_DEFAULT = 8;
   localparam int MAX_FRAGS_DEFAULT  = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd60;

   typedef enum logic [1:0] {
      ST_PENDING    = 2'd0,
      ST_DONE       = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_GROUP_FULL = 2'd3
   } status_type;

   typedef struct packed {
      logic        action;
      logic [15:0] ip_ident;
      logic [7:0]  ip_proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [12:0] frag_offset;
      logic        more_frags;
      logic [15:0] total_length;
      logic [3:0]  header_words;
      logic [7:0]  frag_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_tag;
      logic [5:0]  strip_bytes;
      logic [15:0] new_total_length;
      logic        last;
   } rsp_type;

   // Stored fragment entry, most significant field first.
   typedef struct packed {
      logic [7:0]  tag;
      logic [3:0]  ihl;
      logic [15:0] len;
      logic        mf;
      logic [12:0] off;
   } frag_entry_type;

   typedef struct packed {
      logic [15:0] ident;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
   } group_key_type;

endpackage

// File: hdl/ifrt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while no read is enabled. No dependencies.
module ifrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ip_fragment_reassembly_tracker_core.sv
// Top level of the IPv4 fragment reassembly tracker: sequencer around three RAMs.
// Depends on ifrt_pkg and ifrt_ram.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  request | req_valid, req_ready, req_data | in
//  result  | rsp_valid, rsp_ready, rsp_data | out
//  config  | csr_valid, csr_ready, csr_wdata| in
//
// A fragment's key search reads the key of each valid group and skips free slots; the
// sorted insert reads and rewrites each shifted entry, the contiguity check reads each
// stored entry and each emitted part is read, then sent; the single read port of each
// RAM sets this. A tick reads and rewrites each valid group's metadata and skips free
// slots. Reset clears the state and valid flags and loads TIMEOUT_RESET. A stalled
// result output holds the sequencer; requests are taken only when idle.
module ip_fragment_reassembly_tracker_core #(
   parameter int MAX_GROUPS = ifrt_pkg::MAX_GROUPS_DEFAULT,
   parameter int MAX_FRAGS  = ifrt_pkg::MAX_FRAGS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ifrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ifrt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_wdata
);
   import ifrt_pkg::*;

   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW    = $clog2(MAX_FRAGS + 1);
   localparam int DEPTH = MAX_GROUPS * MAX_FRAGS;
   localparam int AW    = $clog2(DEPTH);
   localparam int MW    = 16 + CW;
   localparam int KW    = $bits(group_key_type);
   localparam int EW    = $bits(frag_entry_type);
   localparam logic [GW-1:0] LAST_GRP = GW'(MAX_GROUPS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_FRAGS);

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_SRCH    = 14'b00000000000010,
      S_SCMP    = 14'b00000000000100,
      S_NEW     = 14'b00000000001000,
      S_META    = 14'b00000000010000,
      S_INS_RD  = 14'b00000000100000,
      S_INS_WR  = 14'b00000001000000,
      S_CHK_RD  = 14'b00000010000000,
      S_CHK     = 14'b00000100000000,
      S_RESP    = 14'b00001000000000,
      S_EM_RD   = 14'b00010000000000,
      S_EM      = 14'b00100000000000,
      S_TICK_RD = 14'b01000000000000,
      S_TICK_WR = 14'b10000000000000
   } state_type;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [GW-1:0]         grp_ff, grp_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [15:0]           age_ff, age_in;
   logic signed [17:0]    expect_ff, expect_in;
   logic                  ok_ff, ok_in;
   logic [3:0]            fihl_ff, fihl_in;
   logic [15:0]           ntl_ff, ntl_in;
   logic [1:0]            status_ff, status_in;
   logic [MAX_GROUPS-1:0] valid_ff, valid_in;
   logic [15:0]           timeout_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  key_wr_en, key_rd_en;
   logic [KW-1:0]         key_rd_data;
   group_key_type         req_key;
   logic                  meta_wr_en, meta_rd_en;
   logic [MW-1:0]         meta_wr_data, meta_rd_data;
   logic                  frag_wr_en, frag_rd_en;
   logic [AW-1:0]         frag_wr_addr, frag_rd_addr;
   frag_entry_type        frag_wr_data, frag_rd_e, new_e;
   logic [EW-1:0]         frag_rd_data;

   logic                  slot_free, has_free;
   logic [GW-1:0]         free_grp;
   logic signed [17:0]    cur_pos, end_pos;
   logic                  ok_now;
   logic [3:0]            first_ihl;
   logic [15:0]           age_inc;

   ifrt_ram #(.WIDTH(KW), .DEPTH(MAX_GROUPS)) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr_en),
      .wr_addr(grp_in),
      .wr_data(req_key),
      .rd_en  (key_rd_en),
      .rd_addr(grp_ff),
      .rd_data(key_rd_data)
   );

   ifrt_ram #(.WIDTH(MW), .DEPTH(MAX_GROUPS)) u_meta_ram (
      .clock  (clock),
      .wr_en  (meta_wr_en),
      .wr_addr(grp_ff),
      .wr_data(meta_wr_data),
      .rd_en  (meta_rd_en),
      .rd_addr(grp_ff),
      .rd_data(meta_rd_data)
   );

   ifrt_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_frag_ram (
      .clock  (clock),
      .wr_en  (frag_wr_en),
      .wr_addr(frag_wr_addr),
      .wr_data(frag_wr_data),
      .rd_en  (frag_rd_en),
      .rd_addr(frag_rd_addr),
      .rd_data(frag_rd_data)
   );

   assign req_key   = '{ident: req_ff.ip_ident, proto: req_ff.ip_proto,
                        src: req_ff.src_addr, dst: req_ff.dst_addr};
   assign new_e     = '{tag: req_ff.frag_tag, ihl: req_ff.header_words,
                        len: req_ff.total_length, mf: req_ff.more_frags,
                        off: req_ff.frag_offset};
   assign frag_rd_e = frag_rd_data;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      has_free = 1'b0;
      free_grp = '0;
      for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
         if (!valid_ff[g]) begin
            has_free = 1'b1;
            free_grp = GW'(g);
         end
      end
   end

   // Contiguity step on the entry just read.
   assign cur_pos   = {2'b00, frag_rd_e.off, 3'b000};
   assign end_pos   = cur_pos + {2'b00, frag_rd_e.len} - {12'd0, frag_rd_e.ihl, 2'b00};
   assign ok_now    = ok_ff && (cur_pos == expect_ff);
   assign first_ihl = (idx_ff == '0) ? frag_rd_e.ihl : fihl_ff;
   assign age_inc   = (meta_rd_data[MW-1 -: 16] == 16'hFFFF) ? 16'hFFFF
                      : meta_rd_data[MW-1 -: 16] + 16'd1;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      grp_in       = grp_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      age_in       = age_ff;
      expect_in    = expect_ff;
      ok_in        = ok_ff;
      fihl_in      = fihl_ff;
      ntl_in       = ntl_ff;
      status_in    = status_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      key_wr_en    = 1'b0;
      key_rd_en    = 1'b0;
      meta_wr_en   = 1'b0;
      meta_rd_en   = 1'b0;
      meta_wr_data = {age_ff, cnt_ff};
      frag_wr_en   = 1'b0;
      frag_rd_en   = 1'b0;
      frag_wr_addr = AW'(grp_ff) * AW'(MAX_FRAGS) + AW'(idx_ff);
      frag_rd_addr = AW'(grp_ff) * AW'(MAX_FRAGS) + AW'(idx_ff);
      frag_wr_data = new_e;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               grp_in   = '0;
               state_in = req_data.action ? S_TICK_RD : S_SRCH;
            end
         end
         S_SRCH: begin
            if (valid_ff[grp_ff]) begin
               key_rd_en = 1'b1;
               state_in  = S_SCMP;
            end else if (grp_ff == LAST_GRP) begin
               state_in = S_NEW;
            end else begin
               grp_in = grp_ff + GW'(1);
            end
         end
         S_SCMP: begin
            if (key_rd_data == req_key) begin
               meta_rd_en = 1'b1;
               state_in   = S_META;
            end else if (grp_ff == LAST_GRP) begin
               state_in = S_NEW;
            end else begin
               grp_in   = grp_ff + GW'(1);
               state_in = S_SRCH;
            end
         end
         S_NEW: begin
            if (!has_free) begin
               status_in = ST_TABLE_FULL;
               state_in  = S_RESP;
            end else begin
               grp_in             = free_grp;
               key_wr_en          = 1'b1;
               valid_in[free_grp] = 1'b1;
               cnt_in             = '0;
               age_in             = '0;
               idx_in             = '0;
               state_in           = S_INS_RD;
            end
         end
         S_META: begin
            cnt_in = meta_rd_data[CW-1:0];
            age_in = meta_rd_data[MW-1 -: 16];
            idx_in = meta_rd_data[CW-1:0];
            if (meta_rd_data[CW-1:0] == FULL_CNT) begin
               status_in = ST_GROUP_FULL;
               state_in  = S_RESP;
            end else begin
               state_in = S_INS_RD;
            end
         end
         // Walk down from the end: larger offsets move up by one slot.
         S_INS_RD: begin
            if (idx_ff == '0) begin
               frag_wr_en   = 1'b1;
               meta_wr_en   = 1'b1;
               meta_wr_data = {age_ff, cnt_ff + CW'(1)};
               cnt_in       = cnt_ff + CW'(1);
               expect_in    = '0;
               ok_in        = 1'b1;
               state_in     = S_CHK_RD;
            end else begin
               frag_rd_en   = 1'b1;
               frag_rd_addr = AW'(grp_ff) * AW'(MAX_FRAGS) + AW'(idx_ff - CW'(1));
               state_in     = S_INS_WR;
            end
         end
         S_INS_WR: begin
            frag_wr_en = 1'b1;
            if (frag_rd_e.off > req_ff.frag_offset) begin
               frag_wr_data = frag_rd_e;
               idx_in       = idx_ff - CW'(1);
               state_in     = S_INS_RD;
            end else begin
               meta_wr_en   = 1'b1;
               meta_wr_data = {age_ff, cnt_ff + CW'(1)};
               cnt_in       = cnt_ff + CW'(1);
               idx_in       = '0;
               expect_in    = '0;
               ok_in        = 1'b1;
               state_in     = S_CHK_RD;
            end
         end
         S_CHK_RD: begin
            frag_rd_en = 1'b1;
            state_in   = S_CHK;
         end
         S_CHK: begin
            ok_in   = ok_now;
            fihl_in = first_ihl;
            if (ok_now) begin
               expect_in = end_pos;
            end
            if (idx_ff + CW'(1) == cnt_ff) begin
               ntl_in = end_pos[15:0] + {10'd0, first_ihl, 2'b00};
               idx_in = '0;
               if (ok_now && !frag_rd_e.mf) begin
                  state_in = S_EM_RD;
               end else begin
                  status_in = ST_PENDING;
                  state_in  = S_RESP;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_CHK_RD;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: status_ff, out_tag: '0, strip_bytes: '0,
                                new_total_length: '0, last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         S_EM_RD: begin
            frag_rd_en = 1'b1;
            state_in   = S_EM;
         end
         S_EM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: ST_DONE, out_tag: frag_rd_e.tag,
                                strip_bytes: (idx_ff == '0) ? 6'd0 : {frag_rd_e.ihl, 2'b00},
                                new_total_length: ntl_ff,
                                last: (idx_ff + CW'(1) == cnt_ff)};
               if (idx_ff + CW'(1) == cnt_ff) begin
                  valid_in[grp_ff] = 1'b0;
                  state_in         = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_EM_RD;
               end
            end
         end
         S_TICK_RD: begin
            if (valid_ff[grp_ff]) begin
               meta_rd_en = 1'b1;
               state_in   = S_TICK_WR;
            end else if (grp_ff == LAST_GRP) begin
               state_in = S_IDLE;
            end else begin
               grp_in = grp_ff + GW'(1);
            end
         end
         S_TICK_WR: begin
            meta_wr_en   = 1'b1;
            meta_wr_data = {age_inc, meta_rd_data[CW-1:0]};
            if (age_inc >= timeout_ff) begin
               valid_in[grp_ff] = 1'b0;
            end
            if (grp_ff == LAST_GRP) begin
               state_in = S_IDLE;
            end else begin
               grp_in   = grp_ff + GW'(1);
               state_in = S_TICK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      grp_ff      <= grp_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      age_ff      <= age_in;
      expect_ff   <= expect_in;
      ok_ff       <= ok_in;
      fihl_ff     <= fihl_in;
      ntl_ff      <= ntl_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/ifrt_checker.sv
// Result checker for the fragment reassembly tracker: watches the request, result and
// register channels, predicts the results and compares them. Depends on ifrt_pkg.
`timescale 1ns / 100ps
module ifrt_checker #(
   parameter int MAX_GROUPS = 8,
   parameter int MAX_FRAGS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ifrt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ifrt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [15:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count,
   output int                done_parts,
   output int                frag_count
);
   import ifrt_pkg::*;

   logic                  grp_valid [MAX_GROUPS];
   group_key_type         grp_key   [MAX_GROUPS];
   logic [15:0]           grp_age   [MAX_GROUPS];
   int                    grp_count [MAX_GROUPS];
   frag_entry_type        grp_frag  [MAX_GROUPS][MAX_FRAGS];
   logic [15:0]           timeout_ticks;
   rsp_type               expected_rsp[$];

   function automatic rsp_type make_rsp(status_type st, logic [7:0] tag, logic [5:0] strip,
                                        logic [15:0] ntl, logic lst);
      rsp_type r;
      r.status = st;
      r.out_tag = tag;
      r.strip_bytes = strip;
      r.new_total_length = ntl;
      r.last = lst;
      return r;
   endfunction

   task automatic track_fragment(req_type rq);
      group_key_type k;
      frag_entry_type e;
      int g, i, n, pos;
      int found;
      int next_start;
      logic complete;
      logic [15:0] payload, ntl;
      frag_entry_type le;
      k.ident = rq.ip_ident;
      k.proto = rq.ip_proto;
      k.src = rq.src_addr;
      k.dst = rq.dst_addr;
      e.off = rq.frag_offset;
      e.mf = rq.more_frags;
      e.len = rq.total_length;
      e.ihl = rq.header_words;
      e.tag = rq.frag_tag;
      found = -1;
      for (g = 0; g < MAX_GROUPS && found < 0; g++)
         if (grp_valid[g] && grp_key[g] == k) found = g;
      if (found < 0) begin
         for (g = 0; g < MAX_GROUPS && found < 0; g++)
            if (!grp_valid[g]) found = g;
         if (found < 0) begin
            expected_rsp.push_back(make_rsp(ST_TABLE_FULL, 0, 0, 0, 1));
            return;
         end
         grp_valid[found] = 1;
         grp_key[found] = k;
         grp_age[found] = 0;
         grp_count[found] = 0;
      end
      g = found;
      n = grp_count[g];
      if (n >= MAX_FRAGS) begin
         expected_rsp.push_back(make_rsp(ST_GROUP_FULL, 0, 0, 0, 1));
         return;
      end
      pos = n;
      for (i = 0; i < n; i++)
         if (grp_frag[g][i].off > e.off) begin
            pos = i;
            break;
         end
      for (i = n; i > pos; i--) grp_frag[g][i] = grp_frag[g][i-1];
      grp_frag[g][pos] = e;
      n++;
      grp_count[g] = n;
      // Contiguity is judged in plain integers, so a negative end just breaks the run.
      next_start = 0;
      complete = 1;
      for (i = 0; i < n && complete; i++) begin
         if (int'(grp_frag[g][i].off) * 8 != next_start) complete = 0;
         else next_start = int'(grp_frag[g][i].off) * 8 + int'(grp_frag[g][i].len)
                           - int'(grp_frag[g][i].ihl) * 4;
      end
      if (complete && grp_frag[g][n-1].mf) complete = 0;
      if (!complete) begin
         expected_rsp.push_back(make_rsp(ST_PENDING, 0, 0, 0, 1));
         return;
      end
      le = grp_frag[g][n-1];
      payload = 16'({le.off, 3'b000} + le.len - {le.ihl, 2'b00});
      ntl = payload + 16'({grp_frag[g][0].ihl, 2'b00});
      for (i = 0; i < n; i++)
         expected_rsp.push_back(make_rsp(ST_DONE, grp_frag[g][i].tag,
                                i == 0 ? 6'd0 : {grp_frag[g][i].ihl, 2'b00}, ntl, i == n-1));
      grp_valid[g] = 0;
   endtask

   task automatic age_groups();
      int g;
      for (g = 0; g < MAX_GROUPS; g++) begin
         if (!grp_valid[g]) continue;
         if (grp_age[g] != 16'hFFFF) grp_age[g]++;
         if (grp_age[g] >= timeout_ticks) grp_valid[g] = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int g = 0; g < MAX_GROUPS; g++) grp_valid[g] = 0;
         timeout_ticks = TIMEOUT_RESET;
         expected_rsp.delete();
         fail_count = 0;
         done_parts = 0;
         frag_count = 0;
      end else begin
         if (csr_valid && csr_ready) timeout_ticks = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data != want) begin
                  $display("%0t: result mismatch, expected %p, actual %p",
                           $time, want, rsp_data);
                  fail_count++;
               end
               if (want.status == ST_DONE) done_parts++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.action) age_groups();
            else begin
               frag_count++;
               track_fragment(req_data);
            end
         end
      end
      pending_count = expected_rsp.size();
   end
endmodule

// File: sim/ip_fragment_reassembly_tracker_core_tb.sv
// Testbench top for the fragment reassembly tracker: clock, reset, request and register
// stimulus and the verdict. Depends on ifrt_pkg, ifrt_checker and the block itself.
`timescale 1ns / 100ps
module ip_fragment_reassembly_tracker_core_tb;
   import ifrt_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_wdata = 0;
   int          fail_count, pending_count, done_parts, frag_count;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;
   int          sent = 0;

   localparam int CYCLE_LIMIT = 2000000;

   // A few keys reused so that fragments find their groups; key 0 is all zeros.
   group_key_type key_pool[12];

   always #4 clock = ~clock;

   ip_fragment_reassembly_tracker_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_wdata
   );

   ifrt_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_wdata, .fail_count, .pending_count,
      .done_parts, .frag_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Valid stays high from one request to the next unless the sender idles.
   task automatic send_request(req_type rq);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // A tick gives no result, so leave room for one still being worked on.
      repeat (40) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] v);
      drain();
      csr_valid <= 1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type frag(group_key_type k, int off, bit mf, int len, int ihl,
                                    int tag);
      req_type r;
      r = '0;
      r.ip_ident = k.ident;
      r.ip_proto = k.proto;
      r.src_addr = k.src;
      r.dst_addr = k.dst;
      r.frag_offset = 13'(off);
      r.more_frags = mf;
      r.total_length = 16'(len);
      r.header_words = 4'(ihl);
      r.frag_tag = 8'(tag);
      return r;
   endfunction

   function automatic req_type tick();
      req_type r;
      r = '0;
      r.action = 1;
      return r;
   endfunction

   function automatic req_type noise();
      req_type r;
      r = '0;
      r.ip_ident = 16'($urandom);
      r.ip_proto = 8'($urandom);
      r.src_addr = $urandom;
      r.dst_addr = $urandom;
      r.frag_offset = 13'($urandom);
      r.more_frags = 1'($urandom);
      r.total_length = 16'($urandom);
      r.header_words = 4'($urandom_range(15, 5));
      r.frag_tag = 8'($urandom);
      return r;
   endfunction

   // Sends one well-formed packet of n fragments, shuffled, with random payload sizes.
   task automatic send_packet(group_key_type k, int n);
      int offs[16];
      int lens[16];
      int ihls[16];
      int order[16];
      int pos, i, j, t;
      pos = 0;
      for (i = 0; i < n; i++) begin
         ihls[i] = $urandom_range(15, 5);
         offs[i] = pos;
         lens[i] = ihls[i] * 4 + 8 * $urandom_range(1, 40);
         if (i == n - 1 && $urandom_range(3) == 0) lens[i] = ihls[i] * 4 + $urandom_range(1, 7);
         pos += (lens[i] - ihls[i] * 4) / 8;
         order[i] = i;
      end
      for (i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (i = 0; i < n; i++) begin
         j = order[i];
         send_request(frag(k, offs[j], j != n - 1, lens[j], ihls[j], $urandom_range(255)));
         if ($urandom_range(15) == 0) send_request(tick());
      end
   endtask

   initial begin
      group_key_type k;
      int i, n;
      for (i = 0; i < 12; i++) begin
         key_pool[i].ident = 16'($urandom);
         key_pool[i].proto = 8'($urandom);
         key_pool[i].src = $urandom;
         key_pool[i].dst = $urandom;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: single-fragment packets at the field extremes.
      send_request(frag(key_pool[0], 0, 0, 20, 5, 0));
      send_request(frag(key_pool[1], 0, 0, 16'hFFFF, 15, 255));
      // Header longer than the fragment: a lone first fragment still completes,
      // with a negative end that wraps in the new total length.
      send_request(frag(key_pool[2], 0, 0, 10, 15, 7));
      // Two fragments at equal offset with the tail between them: the later one goes after.
      send_request(frag(key_pool[3], 0, 1, 28, 5, 1));
      send_request(frag(key_pool[3], 8191, 0, 16'hFFFF, 5, 2));
      send_request(frag(key_pool[3], 0, 1, 28, 5, 3));
      // Fill the table, then one more new key is refused.
      for (i = 4; i < 11; i++) send_request(frag(key_pool[i], 1, 1, 100, 5, i));
      send_request(frag(key_pool[11], 1, 1, 100, 6, 99));
      // Fill one group beyond its capacity.
      for (i = 0; i < 16; i++) send_request(frag(key_pool[4], 2 + i, 1, 40, 5, 20 + i));
      write_timeout(1);
      send_request(tick());
      write_timeout(16'hFFFF);
      send_packet(key_pool[5], 3);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         write_timeout(phase == 3 ? 16'd3 : 16'($urandom_range(5, 200)));
         n = sent + 60;
         while (sent < n) begin
            case ($urandom_range(9))
               0: send_request(noise());
               1: send_request(tick());
               2: begin
                  k = key_pool[$urandom_range(11)];
                  send_request(frag(k, $urandom_range(8191), $urandom_range(1) == 1, $urandom,
                                    $urandom_range(15, 5), $urandom_range(255)));
               end
               default: send_packet(key_pool[$urandom_range(11)], $urandom_range(1, 6));
            endcase
         end
         // Let every result come home before the next phase.
         drain();
      end
      stall_pct = 0;
      write_timeout(0);
      send_request(tick());
      drain();

      $display("%0d requests, %0d fragments, %0d completed parts checked",
               sent, frag_count, done_parts);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// File: sim.f
hdl/ifrt_pkg.sv
hdl/ifrt_ram.sv
hdl/ip_fragment_reassembly_tracker_core.sv
sim/ifrt_checker.sv
sim/ip_fragment_reassembly_tracker_core_tb.sv
